>>> design/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Types and codes shared by the address region table and its checker.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned PAGE_W = 21;
  localparam int unsigned OFFS_W = 20;

  localparam logic [PAGE_W-1:0] SPACE_END_RESET = 21'h10_0000;

  // operation codes
  localparam logic [2:0] F_ADD       = 3'd0;
  localparam logic [2:0] F_FIND      = 3'd1;
  localparam logic [2:0] F_REMOVE    = 3'd2;
  localparam logic [2:0] F_FINDSPACE = 3'd3;
  localparam logic [2:0] F_RESIZE    = 3'd4;
  localparam logic [2:0] F_FAULT     = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // access kinds
  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_SPACE_START = 2'd0;
  localparam logic [1:0] CFG_SPACE_END   = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DEC,
    S_SHIFT,
    S_COMPACT
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0] pg_start;
    logic [PAGE_W-1:0] pg_end;
    logic [2:0]        perm;
  } rec_t;

endpackage

>>> design/address_region_table.sv
// ----------------------------------------------------------------------------
// address_region_table
// Sorted table of page regions with add, find, remove, first-fit search,
// resize and fault checks, run by a sequencer over one compare unit.
// ----------------------------------------------------------------------------
// walks go through the order list one region per cycle behind a
//   two-stage memory read for every item but a rejected one; add then
//   moves the regions above its place up to open it, remove moves the
//   later regions down to close the gap; rejected items answer from idle
// throughput: one item at a time, busy stays high until the result beat
// reset: table empty, space registers at their defaults; no clearing pass
// results are shown for one cycle on result_valid_o; the receiver cannot stall
module address_region_table
  import art_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned PAGE_SHIFT    = 12,
  parameter int unsigned ADDR_BITS     = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [PAGE_W-1:0]   cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          func_i,
  input  logic [PAGE_W-1:0]   first_page_i,
  input  logic [PAGE_W-1:0]   second_page_i,
  input  logic [2:0]          prot_i,
  input  logic [3:0]          entry_slot_i,
  input  logic [31:0]         address_i,
  input  logic [1:0]          access_type_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [PAGE_W-1:0]   result_page_o,
  output logic [PAGE_W-1:0]   region_end_page_o,
  output logic [2:0]          region_prot_o,
  output logic [3:0]          region_slot_o,
  output logic [OFFS_W-1:0]   fault_page_offset_o,
  output logic [4:0]          region_count_o
);

  localparam int unsigned SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [31:0] AddrMask =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [CW-1:0] Entries = CW'(TABLE_ENTRIES);

  // memories
  logic [SW-1:0] ord_mem [TABLE_ENTRIES];
  rec_t          rec_mem [TABLE_ENTRIES];
  logic [SW-1:0] ord_rdata_q;
  rec_t          rec_rdata_q;
  logic          ord_we, rec_we;
  logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, rec_waddr;
  rec_t          rec_wdata;

  state_e state_q, state_d;

  logic [PAGE_W-1:0] sstart_q, send_q;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0] held_q, held_d;

  // latched item
  logic [2:0]        func_q;
  logic [PAGE_W-1:0] p1_q, p2_q;
  logic [2:0]        prot_q;
  logic [SW-1:0]     slot_q;
  logic [1:0]        acc_q;
  logic [31:0]       page_q;

  // walk pipeline
  logic [CW-1:0] ri_q, ri_d, pos1_q, pos2_q;
  logic          v1_q, v1_d, v2_q, v2_d;
  logic [SW-1:0] slot2_q;

  // search state
  logic              dup_q, dup_d, hit_q, hit_d, after_q, after_d, found_q, found_d;
  logic [SW-1:0]     dup_slot_q, dup_slot_d, hit_slot_q, hit_slot_d;
  rec_t              hit_rec_q, hit_rec_d;
  logic [CW-1:0]     ins_pos_q, ins_pos_d, fs_q, fs_d, d_q, d_d, wdest_q, wdest_d;
  logic              pend_q, pend_d;
  logic [PAGE_W-1:0] ge_q, ge_d, st_q, st_d;

  // result registers
  logic              res_fire, rv_q;
  logic [1:0]        res_status, status_q;
  logic [PAGE_W-1:0] res_page, page_oq, res_end, end_oq;
  logic [2:0]        res_prot, prot_oq;
  logic [SW-1:0]     res_slot;
  logic [3:0]        slot_oq;
  logic [OFFS_W-1:0] res_offs, offs_oq;
  logic [4:0]        count_oq;

  // shared flags
  logic              accept, slot_ok_in, pre_done, range_bad, fs_ovf;
  logic [PAGE_W-1:0] st0;
  logic              e_hit, e_fit, drained, fs_done, walk_stop, walk_leave;
  logic              full, shift_end, compact_end, perm_ok, rs_ok;
  logic [PAGE_W:0]   st_len;

  assign accept     = start && (state_q == S_IDLE);
  assign slot_ok_in = (32'(entry_slot_i) < TABLE_ENTRIES) && valid_q[SW'(entry_slot_i)];
  assign st0        = (first_page_i < sstart_q) ? sstart_q : first_page_i;
  assign fs_ovf     = ({1'b0, st0} + {1'b0, second_page_i}) > {1'b0, send_q};
  assign range_bad  = (first_page_i < sstart_q) || (second_page_i > send_q) ||
                      (second_page_i < first_page_i);

  always_comb begin
    unique case (func_i)
      F_ADD:                pre_done = range_bad;
      F_FIND, F_FAULT:      pre_done = 1'b0;
      F_REMOVE, F_RESIZE:   pre_done = !slot_ok_in;
      F_FINDSPACE:          pre_done = fs_ovf || (held_q == '0);
      default:              pre_done = 1'b1;
    endcase
  end

  // the shared compare unit looks at one region per cycle
  assign st_len  = {1'b0, st_q} + {1'b0, p2_q};
  assign e_hit   = ({11'b0, rec_rdata_q.pg_start} <= page_q) &&
                   (page_q < {11'b0, rec_rdata_q.pg_end});
  assign e_fit   = st_len <= {1'b0, rec_rdata_q.pg_start};
  assign drained = !v1_q && !v2_q && (ri_q >= held_q);
  assign fs_done = (fs_q >= Entries) || !valid_q[SW'(fs_q)];

  always_comb begin
    unique case (func_q)
      F_FIND, F_FAULT: walk_stop = v2_q && e_hit;
      F_REMOVE:        walk_stop = v2_q && (slot2_q == slot_q);
      F_RESIZE:        walk_stop = v2_q && after_q;
      F_FINDSPACE:     walk_stop = v2_q && e_fit;
      default:         walk_stop = 1'b0;
    endcase
  end

  assign walk_leave  = walk_stop || (drained && ((func_q != F_ADD) || fs_done));
  assign full        = held_q >= Entries;
  assign shift_end   = (d_q == ins_pos_q) && !pend_q;
  assign compact_end = (({1'b0, d_q} + 1'b1) >= {1'b0, held_q}) && !pend_q;

  assign perm_ok = (hit_rec_q.perm != 3'd0) &&
                   !((acc_q == ACC_WRITE) && !hit_rec_q.perm[1]) &&
                   !((acc_q == ACC_READ) && !hit_rec_q.perm[0]);
  assign rs_ok   = (p2_q > hit_rec_q.pg_end) ? (p2_q <= ge_q)
                                             : (p2_q >= hit_rec_q.pg_start);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !pre_done) state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_leave) state_d = S_DEC;
      end
      S_DEC: begin
        if (func_q == F_ADD) begin
          state_d = (!dup_q && !full) ? S_SHIFT : S_IDLE;
        end else if (func_q == F_REMOVE) begin
          state_d = S_COMPACT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (shift_end) state_d = S_IDLE;
      end
      S_COMPACT: begin
        if (compact_end) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    valid_d    = valid_q;
    held_d     = held_q;
    ri_d       = ri_q;
    v1_d       = 1'b0;
    v2_d       = 1'b0;
    dup_d      = dup_q;
    dup_slot_d = dup_slot_q;
    hit_d      = hit_q;
    hit_slot_d = hit_slot_q;
    hit_rec_d  = hit_rec_q;
    after_d    = after_q;
    found_d    = found_q;
    ins_pos_d  = ins_pos_q;
    fs_d       = fs_q;
    d_d        = d_q;
    wdest_d    = wdest_q;
    pend_d     = 1'b0;
    ge_d       = ge_q;
    st_d       = st_q;
    ord_we     = 1'b0;
    ord_waddr  = SW'(wdest_q);
    ord_wdata  = ord_rdata_q;
    ord_raddr  = SW'(ri_q);
    rec_we     = 1'b0;
    rec_waddr  = slot_q;
    rec_wdata  = '{pg_start: hit_rec_q.pg_start, pg_end: p2_q, perm: hit_rec_q.perm};
    res_fire   = 1'b0;
    res_status = ST_FAIL;
    res_page   = '0;
    res_end    = '0;
    res_prot   = '0;
    res_slot   = '0;
    res_offs   = '0;

    unique case (state_q)
      S_IDLE: begin
        dup_d   = 1'b0;
        hit_d   = 1'b0;
        after_d = 1'b0;
        found_d = 1'b0;
        ins_pos_d = '0;
        fs_d    = '0;
        ri_d    = '0;
        ge_d    = send_q;
        st_d    = st0;
        if (accept && pre_done) begin
          res_fire = 1'b1;
          if (func_i == F_ADD) begin
            res_status = ST_BAD;
          end else if ((func_i == F_FINDSPACE) && !fs_ovf) begin
            res_status = ST_OK;
            res_page   = st0;
          end
        end
      end
      S_WALK: begin
        ord_raddr = SW'(ri_q);
        if (!walk_leave) begin
          v1_d = ri_q < held_q;
          v2_d = v1_q;
          if (ri_q < held_q) ri_d = ri_q + 1'b1;
        end
        if ((func_q == F_ADD) && !fs_done) fs_d = fs_q + 1'b1;
        if (v2_q) begin
          unique case (func_q)
            F_ADD: begin
              if (rec_rdata_q.pg_start == p1_q) begin
                dup_d      = 1'b1;
                dup_slot_d = slot2_q;
              end
              if (rec_rdata_q.pg_start < p1_q) ins_pos_d = pos2_q + 1'b1;
            end
            F_FIND, F_FAULT: begin
              if (e_hit) begin
                hit_d      = 1'b1;
                hit_rec_d  = rec_rdata_q;
                hit_slot_d = slot2_q;
              end
            end
            F_REMOVE: begin
              if (slot2_q == slot_q) begin
                hit_rec_d = rec_rdata_q;
                d_d       = pos2_q;
              end
            end
            F_RESIZE: begin
              if (after_q) begin
                ge_d = rec_rdata_q.pg_start;
              end else if (slot2_q == slot_q) begin
                hit_rec_d = rec_rdata_q;
                after_d   = 1'b1;
              end
            end
            F_FINDSPACE: begin
              if (e_fit) begin
                found_d = 1'b1;
              end else if (st_q < rec_rdata_q.pg_end) begin
                st_d = rec_rdata_q.pg_end;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEC: begin
        d_d = (func_q == F_ADD) ? held_q : d_q;
        unique case (func_q)
          F_ADD: begin
            if (dup_q) begin
              res_fire   = 1'b1;
              res_status = ST_BAD;
              res_slot   = dup_slot_q;
            end else if (full) begin
              res_fire   = 1'b1;
              res_status = ST_FULL;
            end
          end
          F_FIND, F_FAULT: begin
            res_fire = 1'b1;
            if (hit_q && ((func_q == F_FIND) || perm_ok)) begin
              res_status = ST_OK;
              res_page   = hit_rec_q.pg_start;
              res_end    = hit_rec_q.pg_end;
              res_prot   = hit_rec_q.perm;
              res_slot   = hit_slot_q;
              if (func_q == F_FAULT) begin
                res_offs = OFFS_W'(page_q - {11'b0, hit_rec_q.pg_start});
              end
            end
          end
          F_FINDSPACE: begin
            res_fire = 1'b1;
            if (found_q || (st_len <= {1'b0, send_q})) begin
              res_status = ST_OK;
              res_page   = st_q;
            end
          end
          F_RESIZE: begin
            res_fire   = 1'b1;
            res_page   = hit_rec_q.pg_start;
            res_end    = hit_rec_q.pg_end;
            res_prot   = hit_rec_q.perm;
            res_slot   = slot_q;
            if (rs_ok) begin
              res_status = ST_OK;
              res_end    = p2_q;
              rec_we     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        // move order entries up by one, from the tail down to the insert point
        ord_raddr = SW'(d_q - 1'b1);
        if (pend_q) begin
          ord_we = 1'b1;
        end
        if (d_q > ins_pos_q) begin
          pend_d  = 1'b1;
          wdest_d = d_q;
          d_d     = d_q - 1'b1;
        end
        if (shift_end) begin
          ord_we     = 1'b1;
          ord_waddr  = SW'(ins_pos_q);
          ord_wdata  = SW'(fs_q);
          rec_we     = 1'b1;
          rec_waddr  = SW'(fs_q);
          rec_wdata  = '{pg_start: p1_q, pg_end: p2_q, perm: prot_q};
          valid_d[SW'(fs_q)] = 1'b1;
          held_d     = held_q + 1'b1;
          res_fire   = 1'b1;
          res_status = ST_OK;
          res_page   = p1_q;
          res_end    = p2_q;
          res_prot   = prot_q;
          res_slot   = SW'(fs_q);
        end
      end
      S_COMPACT: begin
        // close the gap left by the removed entry
        ord_raddr = SW'(d_q + 1'b1);
        if (pend_q) begin
          ord_we = 1'b1;
        end
        if (({1'b0, d_q} + 1'b1) < {1'b0, held_q}) begin
          pend_d  = 1'b1;
          wdest_d = d_q;
          d_d     = d_q + 1'b1;
        end
        if (compact_end) begin
          valid_d[slot_q] = 1'b0;
          held_d     = held_q - 1'b1;
          res_fire   = 1'b1;
          res_status = ST_OK;
          res_page   = hit_rec_q.pg_start;
          res_end    = hit_rec_q.pg_end;
          res_prot   = hit_rec_q.perm;
          res_slot   = slot_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rdata_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    rec_rdata_q <= rec_mem[ord_rdata_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sstart_q <= '0;
      send_q   <= SPACE_END_RESET;
      valid_q  <= '0;
      held_q   <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      pend_q   <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_idx_i == CFG_SPACE_START)) sstart_q <= cfg_data_i;
      if (cfg_we_i && (cfg_idx_i == CFG_SPACE_END)) send_q <= cfg_data_i;
      valid_q <= valid_d;
      held_q  <= held_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      pend_q  <= pend_d;
      rv_q    <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      p1_q   <= first_page_i;
      p2_q   <= second_page_i;
      prot_q <= prot_i;
      slot_q <= SW'(entry_slot_i);
      acc_q  <= access_type_i;
      page_q <= (address_i & AddrMask) >> PAGE_SHIFT;
    end
    ri_q       <= ri_d;
    pos1_q     <= ri_q;
    pos2_q     <= pos1_q;
    slot2_q    <= ord_rdata_q;
    dup_q      <= dup_d;
    dup_slot_q <= dup_slot_d;
    hit_q      <= hit_d;
    hit_slot_q <= hit_slot_d;
    hit_rec_q  <= hit_rec_d;
    after_q    <= after_d;
    found_q    <= found_d;
    ins_pos_q  <= ins_pos_d;
    fs_q       <= fs_d;
    d_q        <= d_d;
    wdest_q    <= wdest_d;
    ge_q       <= ge_d;
    st_q       <= st_d;
    if (res_fire) begin
      status_q <= res_status;
      page_oq  <= res_page;
      end_oq   <= res_end;
      prot_oq  <= res_prot;
      slot_oq  <= 4'(res_slot);
      offs_oq  <= res_offs;
      count_oq <= 5'(held_d);
    end
  end

  assign busy                = state_q != S_IDLE;
  assign result_valid_o      = rv_q;
  assign status_o            = status_q;
  assign result_page_o       = page_oq;
  assign region_end_page_o   = end_oq;
  assign region_prot_o       = prot_oq;
  assign region_slot_o       = slot_oq;
  assign fault_page_offset_o = offs_oq;
  assign region_count_o      = count_oq;

endmodule

>>> design/art_chk.sv
// ----------------------------------------------------------------------------
// art_chk
// Port-level checks of the address region table's command handshake.
// ----------------------------------------------------------------------------
module art_chk
  import art_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [1:0] status_o
);

  // a result beat is only shown once the table is free again
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  // an accepted item either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (result_valid_o || busy))
    else $error("accepted item dropped");

  // busy only rises on an accepted item
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

  // each result beat follows an accept or the end of a busy period
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start) || $past(busy)))
    else $error("result beat without an item, status %0d", status_o);

endmodule

bind address_region_table art_chk u_art_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o)
);
